FILE: sv/ordered_list_engine_defines.svh
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shared concurrent check forms, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Request and response types, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ole_pkg;

	localparam int DATA_W = 32;

	// Operation selector
	typedef enum logic [2:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_INS_AFTER  = 3'd2,
		FN_INS_BEFORE = 3'd3,
		FN_POP_FRONT  = 3'd4,
		FN_POP_BACK   = 3'd5,
		FN_DEL_KEY    = 3'd6,
		FN_NOP        = 3'd7
	} ole_func_t;

	// Operation status
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} ole_status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_OPEN,
		S_PUT,
		S_CLOSE,
		S_EMIT_RD,
		S_EMIT_WT
	} ole_state_t;

	typedef struct packed {
		ole_func_t                 func;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] key;
	} ole_req_t;

	typedef struct packed {
		ole_status_t               status;
		logic                      has_value;
		logic signed [DATA_W-1:0] element;
		logic                      last;
	} ole_rsp_t;

endpackage

FILE: sv/ole_ram.sv
// ----------------------------------------------------------------------------
// Ordered list engine RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/ordered_list_engine.sv
// The search compares one entry per cycle and the shift moves one entry per cycle; S_PUT
// then writes the new value, and each response passes through S_EMIT_RD (RAM read) and
// S_EMIT_WT (output load), which waits while the output slot is still held.
// One request is taken at a time, only in S_IDLE, the work being paced by the single RAM
// read and write port. Reset clears the count and the sequencer; entry storage is not
// cleared and needs no clearing.
`include "ordered_list_engine_defines.svh"
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed values in a RAM, updated by a small sequencer
// that searches, shifts and writes one entry per cycle, then streams the list.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  ole_pkg::ole_req_t req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output ole_pkg::ole_rsp_t rsp
);

	import ole_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	ole_state_t state_q, state_d;
	ole_func_t  func_q, func_d;
	logic signed [DATA_W-1:0] value_q, value_d;
	logic signed [DATA_W-1:0] key_q, key_d;
	ole_status_t status_q, status_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] pos_q, pos_d;
	logic [CW-1:0] idx_inc, idx_dec, tag_ext;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_tag_s1;
	ole_rsp_t      rsp_q, rsp_d;
	logic          rsp_valid_q, rsp_load;

	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [DATA_W-1:0] wr_data, rd_data;
	logic              key_hit, slot_free, is_full, is_empty;

	ole_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign idx_inc   = idx_q + 1'b1;
	assign idx_dec   = idx_q - 1'b1;
	assign tag_ext   = CW'(rd_tag_s1);
	assign key_hit   = rd_vld_s1 && (rd_data == key_q);
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign is_full   = (count_q >= CW'(CAPACITY));
	assign is_empty  = (count_q == '0);

	// Sequencer: next state, RAM controls and response load
	always_comb begin
		state_d  = state_q;
		func_d   = func_q;
		value_d  = value_q;
		key_d    = key_q;
		status_d = status_q;
		count_d  = count_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = rd_tag_s1;
		wr_data  = rd_data;
		rsp_load = 1'b0;
		rsp_d    = rsp_q;
		req_ready = (state_q == S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					func_d   = req.func;
					value_d  = req.value;
					key_d    = req.key;
					status_d = ST_OK;
					idx_d    = '0;
					state_d  = S_EMIT_RD;
					case (req.func)
						FN_PUSH_FRONT, FN_PUSH_BACK: begin
							if (is_full) begin
								status_d = ST_FULL;
							end else begin
								pos_d   = (req.func == FN_PUSH_FRONT) ? '0 : count_q;
								idx_d   = count_q;
								state_d = S_OPEN;
							end
						end
						FN_INS_AFTER, FN_INS_BEFORE: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else if (is_full) begin
								status_d = ST_FULL;
							end else begin
								state_d = S_SEARCH;
							end
						end
						FN_POP_FRONT: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_CLOSE;
							end
						end
						FN_POP_BACK: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else begin
								count_d = count_q - 1'b1;
							end
						end
						FN_DEL_KEY: begin
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else begin
								state_d = S_SEARCH;
							end
						end
						default: begin
							status_d = ST_OK;
						end
					endcase
				end
			end

			// Walk entries front to back, compare one per cycle
			S_SEARCH: begin
				if (key_hit) begin
					if (func_q inside {FN_INS_AFTER, FN_INS_BEFORE}) begin
						pos_d   = (func_q == FN_INS_AFTER) ? tag_ext + 1'b1 : tag_ext;
						idx_d   = count_q;
						state_d = S_OPEN;
					end else begin
						idx_d   = tag_ext;
						state_d = S_CLOSE;
					end
				end else if (idx_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_q[AW-1:0];
					idx_d   = idx_inc;
				end else if (!rd_vld_s1) begin
					status_d = ST_NOTFOUND;
					idx_d    = '0;
					state_d  = S_EMIT_RD;
				end
			end

			// Move entries up by one, back to front, down to pos
			S_OPEN: begin
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_tag_s1 + AW'(1);
					wr_data = rd_data;
				end
				if (idx_q > pos_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_dec[AW-1:0];
					idx_d   = idx_dec;
				end else if (!rd_vld_s1) begin
					state_d = S_PUT;
				end
			end

			// Drop the new value into the opened slot
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q[AW-1:0];
				wr_data = value_q;
				count_d = count_q + 1'b1;
				idx_d   = '0;
				state_d = S_EMIT_RD;
			end

			// Move entries down by one over the removed slot
			S_CLOSE: begin
				if (rd_vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = rd_tag_s1 - AW'(1);
					wr_data = rd_data;
				end
				if (idx_inc < count_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_inc[AW-1:0];
					idx_d   = idx_inc;
				end else if (!rd_vld_s1) begin
					count_d = count_q - 1'b1;
					idx_d   = '0;
					state_d = S_EMIT_RD;
				end
			end

			S_EMIT_RD: begin
				if (!is_empty) begin
					rd_en   = 1'b1;
					rd_addr = idx_q[AW-1:0];
				end
				state_d = S_EMIT_WT;
			end

			// Load one response once the output slot frees up
			S_EMIT_WT: begin
				if (slot_free) begin
					rsp_load        = 1'b1;
					rsp_d.status    = status_q;
					rsp_d.has_value = !is_empty;
					rsp_d.element   = is_empty ? '0 : rd_data;
					rsp_d.last      = is_empty || (idx_inc == count_q);
					idx_d           = idx_inc;
					state_d         = rsp_d.last ? S_IDLE : S_EMIT_RD;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_vld_s1   <= rd_en;
			rsp_valid_q <= rsp_load || (rsp_valid_q && !rsp_ready);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		func_q    <= func_d;
		value_q   <= value_d;
		key_q     <= key_d;
		status_q  <= status_d;
		idx_q     <= idx_d;
		pos_q     <= pos_d;
		rd_tag_s1 <= rd_addr;
		rsp_q     <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`OLE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "entry count over capacity")
	`OLE_ASSERT_NEXT(a_last_idle, rsp_load && rsp_d.last, state_q == S_IDLE, "no idle after last")
	`OLE_ASSERT_NOW(a_no_wr_emit, state_q == S_EMIT_RD || state_q == S_EMIT_WT, !wr_en, "write while emitting")
	`OLE_ASSERT_NOW(a_hit_no_rd, state_q == S_SEARCH && key_hit, !rd_en, "read issued on key hit")
	`OLE_ASSERT_NOW(a_load_free, rsp_load, slot_free, "response overwritten")

endmodule
